FILE: src/wbvs_pkg.sv
`default_nettype none
package wbvs_pkg;

  // Counter and field widths
  localparam int COUNT_WIDTH = 32;
  localparam int NUM_DAYS    = 7;
  localparam int NUM_REGS    = 8;
  localparam int WEIGHT_W    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int SCORE_W     = 43;
  localparam int TOTAL_W     = 32;

  // Product of one counter and one weight, and the sum of all eight
  localparam int PROD_W      = COUNT_WIDTH + WEIGHT_W;
  localparam int SUM_W       = PROD_W + 3;
  localparam int SCORE_CMP_W = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;
  localparam int TOTAL_CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX     = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_OUT_MAX = '1;

  // Weekday code for an invalid day
  localparam logic [2:0] DAY_INVALID  = 3'd7;
  // Largest number of buckets one update clears
  localparam logic [2:0] CLEAR_MAX    = 3'd7;
  // Register index of the total weight; indexes below it are the age weights
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TOTAL = 4'd7;

  typedef logic [NUM_REGS-1:0][WEIGHT_W-1:0]    weights_t;
  typedef logic [NUM_DAYS-1:0][COUNT_WIDTH-1:0] counts_t;

  // Weight register reset values, entry 0 is weight_age0
  localparam weights_t WEIGHT_RESET = {8'd1, 8'd15, 8'd15, 8'd20, 8'd20, 8'd25, 8'd30, 8'd50};

  // Updated state handed to the score stages, buckets ordered by age
  typedef struct packed {
    counts_t                age_count;
    logic [COUNT_WIDTH-1:0] total;
  } snap_t;

  // Stage load enables from the pipeline control
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } score_ctl_t;

  // (a - b) mod 7 for weekdays a, b in 0..6
  function automatic logic [2:0] ring_sub(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + 4'd7 - {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // Saturating counter add
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [7:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/wbvs_update.sv
`default_nettype none
module wbvs_update (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [2:0]            day_index,
  input  wire logic [7:0]            days_to_clear,
  input  wire logic [7:0]            increment,
  output wbvs_pkg::snap_t            snap
);

  wbvs_pkg::counts_t                  count_r;
  wbvs_pkg::counts_t                  count_nxt;
  logic [wbvs_pkg::COUNT_WIDTH-1:0]   total_r;
  logic [wbvs_pkg::COUNT_WIDTH-1:0]   total_nxt;
  wbvs_pkg::snap_t                    snap_r;
  wbvs_pkg::snap_t                    snap_nxt;
  logic                               day_ok;
  logic [2:0]                         today;
  logic [2:0]                         n_clr;

  // Clear recent buckets, then add the increment to today's bucket and the total
  always_comb begin
    logic [wbvs_pkg::COUNT_WIDTH-1:0] base;
    day_ok = (day_index != wbvs_pkg::DAY_INVALID);
    today  = day_ok ? day_index : 3'd0;
    n_clr  = (days_to_clear > 8'(wbvs_pkg::CLEAR_MAX)) ? wbvs_pkg::CLEAR_MAX
                                                       : days_to_clear[2:0];
    total_nxt = wbvs_pkg::sat_add(total_r, increment);
    for (int b = 0; b < wbvs_pkg::NUM_DAYS; b++) begin
      base = count_r[b];
      if (day_ok && (wbvs_pkg::ring_sub(today, 3'(b)) < n_clr)) begin
        base = '0;
      end
      if (day_ok && (day_index == 3'(b))) begin
        base = wbvs_pkg::sat_add(base, increment);
      end
      count_nxt[b] = base;
    end
    // Snapshot of the new state, bucket of age k first
    snap_nxt.total = total_nxt;
    for (int k = 0; k < wbvs_pkg::NUM_DAYS; k++) begin
      snap_nxt.age_count[k] = count_nxt[wbvs_pkg::ring_sub(today, 3'(k))];
    end
  end

  // State and snapshot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      total_r      <= '0;
      snap_r.total <= '0;
    end else if (load) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
      snap_r  <= snap_nxt;
    end
  end

  assign snap = snap_r;

endmodule
`default_nettype wire

FILE: src/wbvs_score.sv
`default_nettype none
module wbvs_score (
  input  wire logic                           clk,
  input  wire wbvs_pkg::score_ctl_t           ctl,
  input  wire wbvs_pkg::snap_t                snap,
  input  wire wbvs_pkg::weights_t             weights,
  output logic [wbvs_pkg::SCORE_W-1:0]        score,
  output logic [wbvs_pkg::TOTAL_W-1:0]        total_visits
);

  logic [wbvs_pkg::NUM_REGS-1:0][wbvs_pkg::PROD_W-1:0] prod_r;
  logic [wbvs_pkg::NUM_REGS-1:0][wbvs_pkg::PROD_W-1:0] prod_nxt;
  logic [wbvs_pkg::COUNT_WIDTH-1:0]                    tot_r;
  logic [wbvs_pkg::SUM_W-1:0]                          sum;
  logic [wbvs_pkg::SCORE_CMP_W-1:0]                    sum_ext;
  logic [wbvs_pkg::TOTAL_CMP_W-1:0]                    tot_ext;
  logic [wbvs_pkg::SCORE_W-1:0]                        score_r;
  logic [wbvs_pkg::SCORE_W-1:0]                        score_nxt;
  logic [wbvs_pkg::TOTAL_W-1:0]                        total_r;
  logic [wbvs_pkg::TOTAL_W-1:0]                        total_nxt;

  // One product per age bucket plus the total term
  always_comb begin
    for (int k = 0; k < wbvs_pkg::NUM_DAYS; k++) begin
      prod_nxt[k] = wbvs_pkg::PROD_W'(snap.age_count[k]) * wbvs_pkg::PROD_W'(weights[k]);
    end
    prod_nxt[wbvs_pkg::NUM_REGS-1] = wbvs_pkg::PROD_W'(snap.total)
                                     * wbvs_pkg::PROD_W'(weights[wbvs_pkg::NUM_REGS-1]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= prod_nxt;
      tot_r  <= snap.total;
    end
  end

  // Sum and saturate
  always_comb begin
    sum = '0;
    for (int k = 0; k < wbvs_pkg::NUM_REGS; k++) begin
      sum = sum + wbvs_pkg::SUM_W'(prod_r[k]);
    end
    sum_ext   = wbvs_pkg::SCORE_CMP_W'(sum);
    score_nxt = (sum_ext > wbvs_pkg::SCORE_CMP_W'(wbvs_pkg::SCORE_MAX)) ? wbvs_pkg::SCORE_MAX
                                                               : sum_ext[wbvs_pkg::SCORE_W-1:0];
    tot_ext   = wbvs_pkg::TOTAL_CMP_W'(tot_r);
    total_nxt = (tot_ext > wbvs_pkg::TOTAL_CMP_W'(wbvs_pkg::TOTAL_OUT_MAX))
                ? wbvs_pkg::TOTAL_OUT_MAX : tot_ext[wbvs_pkg::TOTAL_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      score_r <= score_nxt;
      total_r <= total_nxt;
    end
  end

  assign score        = score_r;
  assign total_visits = total_r;

endmodule
`default_nettype wire

FILE: src/weekly_bucket_visit_scorer.sv
`default_nettype none
// Weekly bucket visit scorer: seven weekday counters, a total and a weighted score.
// Throughput: one item per cycle while out_stall is low. Four register stages:
// input, state update and snapshot, products, result.
// Each stage holds when the one after it is full and blocked; out_stall back-pressures.
// Reset (rst_n low, synchronous): counters and total cleared, weights to defaults.
module weekly_bucket_visit_scorer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [2:0]                            in_day_index,
  input  wire logic [7:0]                            in_days_to_clear,
  input  wire logic [7:0]                            in_increment,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [wbvs_pkg::SCORE_W-1:0]               out_score,
  output logic [wbvs_pkg::TOTAL_W-1:0]               out_total_visits,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wbvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wbvs_pkg::WEIGHT_W-1:0]         cfg_data
);

  wbvs_pkg::weights_t    weights_r;
  wbvs_pkg::snap_t       snap;
  wbvs_pkg::score_ctl_t  sctl;
  logic [2:0]            day_r;
  logic [7:0]            clr_r;
  logic [7:0]            inc_r;
  logic                  v0_r, v1_r, v2_r, out_valid_r;
  logic                  v0_nxt, v1_nxt, v2_nxt, out_valid_nxt;
  logic                  rdy0, rdy1, rdy2, rdy3;
  logic                  in_xfer, load_s1;

  // Weight registers; writes past the last register are dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= wbvs_pkg::WEIGHT_RESET;
    end else if (cfg_valid && (cfg_index <= wbvs_pkg::REG_WEIGHT_TOTAL)) begin
      weights_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Stage ready chain: a stage takes new data when empty or moving on
  always_comb begin
    rdy3          = !out_valid_r || !out_stall;
    rdy2          = !v2_r || rdy3;
    rdy1          = !v1_r || rdy2;
    rdy0          = !v0_r || rdy1;
    in_xfer       = in_valid && rdy0;
    load_s1       = v0_r && rdy1;
    sctl.load_prod = v1_r && rdy2;
    sctl.load_out  = v2_r && rdy3;
    v0_nxt        = in_xfer || (v0_r && !rdy1);
    v1_nxt        = load_s1 || (v1_r && !rdy2);
    v2_nxt        = sctl.load_prod || (v2_r && !rdy3);
    out_valid_nxt = sctl.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      day_r <= in_day_index;
      clr_r <= in_days_to_clear;
      inc_r <= in_increment;
    end
  end

  assign in_stall  = !rdy0;
  assign out_valid = out_valid_r;

  wbvs_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load_s1),
    .day_index     (day_r),
    .days_to_clear (clr_r),
    .increment     (inc_r),
    .snap          (snap)
  );

  wbvs_score u_score (
    .clk          (clk),
    .ctl          (sctl),
    .snap         (snap),
    .weights      (weights_r),
    .score        (out_score),
    .total_visits (out_total_visits)
  );

  // Total in the snapshot never goes down
  a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    load_s1 |=> (snap.total >= $past(snap.total)))
    else $error("snapshot total decreased");

  // Products stage holds its item while the result register is blocked
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("products stage dropped an item");

  // Input stall only with a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r)
    else $error("input stalled while input register empty");

endmodule
`default_nettype wire

FILE: test/weekly_bucket_visit_scorer_tb.sv
module weekly_bucket_visit_scorer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbvs_pkg::*;

  // One visit event and the result it should produce
  typedef struct packed {
    logic [2:0] day;
    logic [7:0] gap;
    logic [7:0] inc;
  } visit_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TOTAL_W-1:0] total;
  } tally_t;

  typedef enum int {WT_DEFAULT, WT_MAX, WT_ZERO, WT_RANDOM, WT_MIXED} wt_mode_t;

  localparam logic [WEIGHT_W-1:0] DEFAULT_WT [NUM_REGS] =
    '{8'd50, 8'd30, 8'd25, 8'd20, 8'd20, 8'd15, 8'd15, 8'd1};
  // Indexes past the weight registers; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_day_index = '0;
  logic [7:0] in_days_to_clear = '0;
  logic [7:0] in_increment = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SCORE_W-1:0] out_score;
  logic [TOTAL_W-1:0] out_total_visits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  weekly_bucket_visit_scorer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_day_index     (in_day_index),
    .in_days_to_clear (in_days_to_clear),
    .in_increment     (in_increment),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_score        (out_score),
    .out_total_visits (out_total_visits),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: weekday buckets, total and weights
  logic [COUNT_WIDTH-1:0] bucket [NUM_DAYS];
  logic [COUNT_WIDTH-1:0] visits_total;
  logic [WEIGHT_W-1:0]    weight [NUM_REGS];

  visit_t visit_q [$];
  tally_t tally_due_q [$];

  bit in_xfer = 1'b0;
  bit idle_en = 1'b1;
  int visits_queued = 0;
  int visits_taken = 0;
  int results_checked = 0;
  int fault_count = 0;
  int cfg_writes = 0;
  int weight_sets = 0;
  int quiet_cycles = 0;
  int cal_day = 0;

  function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [7:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  // Clear elapsed buckets, add the increment, then score by bucket age
  function automatic tally_t apply_visit(input visit_t v);
    tally_t r;
    int span;
    int i;
    int today;
    logic [63:0] acc;
    today = 0;
    if (v.day != DAY_INVALID) begin
      span = (v.gap > 8'(CLEAR_MAX)) ? int'(CLEAR_MAX) : int'(v.gap);
      for (i = 0; i < span; i++) begin
        bucket[(NUM_DAYS + int'(v.day) - i) % NUM_DAYS] = '0;
      end
    end
    visits_total = sat_bump(visits_total, v.inc);
    if (v.day != DAY_INVALID) begin
      bucket[v.day] = sat_bump(bucket[v.day], v.inc);
      today = int'(v.day);
    end
    acc = 64'(visits_total) * 64'(weight[REG_WEIGHT_TOTAL[2:0]]);
    for (i = 0; i < NUM_DAYS; i++) begin
      acc += 64'(bucket[i]) * 64'(weight[(NUM_DAYS + today - i) % NUM_DAYS]);
    end
    r.score = (acc > 64'(SCORE_MAX)) ? SCORE_MAX : acc[SCORE_W-1:0];
    r.total = (64'(visits_total) > 64'(TOTAL_OUT_MAX)) ? TOTAL_OUT_MAX
                                                       : TOTAL_W'(visits_total);
    return r;
  endfunction

  function automatic void push_visit(input logic [2:0] d, input logic [7:0] g,
                                     input logic [7:0] n);
    visit_q.push_back('{day: d, gap: g, inc: n});
    visits_queued++;
  endfunction

  // Mostly a consistent calendar walk, the rest arbitrary fields
  function automatic void queue_random(input int count);
    int k;
    int r;
    int delta;
    logic [7:0] n;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 25) begin
        push_visit(3'($urandom_range(7)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end else begin
        r = $urandom_range(99);
        if (r < 60) delta = $urandom_range(2);
        else if (r < 85) delta = $urandom_range(7, 3);
        else delta = $urandom_range(255, 8);
        cal_day = (cal_day + delta) % NUM_DAYS;
        r = $urandom_range(99);
        n = (r < 10) ? 8'd0 : (r < 20) ? 8'hFF : 8'($urandom_range(255));
        push_visit(3'(cal_day), 8'(delta), n);
      end
    end
  endfunction

  // Register write; valid is left high so writes can go back to back
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) weight[idx[2:0]] = data;
    cfg_writes++;
  endtask

  task automatic set_weights(input wt_mode_t mode);
    int i;
    logic [7:0] d;
    for (i = 0; i <= int'(REG_WEIGHT_TOTAL); i++) begin
      case (mode)
        WT_DEFAULT: d = DEFAULT_WT[i];
        WT_MAX:     d = 8'hFF;
        WT_ZERO:    d = 8'h00;
        WT_RANDOM:  d = 8'($urandom_range(255));
        default: begin
          d = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) :
              ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end
      endcase
      cfg_write(CFG_IDX_W'(i), d);
    end
    // Stray write past the register file; must leave the weights alone
    cfg_write(($urandom_range(1) != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
              8'($urandom_range(255)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    weight_sets++;
  endtask

  // Wait until every queued visit has been taken and its result checked
  task automatic drain();
    do @(negedge clk);
    while (visits_taken != visits_queued || tally_due_q.size() != 0);
  endtask

  // Input driver: at each falling edge, hold a stalled transfer, offer a new one or idle; also drives out_stall
  always @(negedge clk) begin : drive_in
    visit_t v;
    out_stall <= idle_en && ($urandom_range(99) < 10);
    if (!in_valid || in_xfer) begin
      if (visit_q.size() != 0 && !(idle_en && $urandom_range(99) < 10)) begin
        v = visit_q.pop_front();
        in_valid         <= 1'b1;
        in_day_index     <= v.day;
        in_days_to_clear <= v.gap;
        in_increment     <= v.inc;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input transfer, check on output transfer, watchdog
  always @(posedge clk) begin : watch
    visit_t v;
    tally_t want;
    bit out_xfer;
    in_xfer  = rst_n && in_valid && !in_stall;
    out_xfer = rst_n && out_valid && !out_stall;
    if (in_xfer) begin
      v = '{day: in_day_index, gap: in_days_to_clear, inc: in_increment};
      tally_due_q.push_back(apply_visit(v));
      visits_taken++;
    end
    if (out_xfer) begin
      if (tally_due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got score %0d total %0d",
                 $time, out_score, out_total_visits);
        fault_count++;
      end else begin
        want = tally_due_q.pop_front();
        if (out_score !== want.score) begin
          $display("%0t: score mismatch: expected %0d, got %0d",
                   $time, want.score, out_score);
          fault_count++;
        end
        if (out_total_visits !== want.total) begin
          $display("%0t: total_visits mismatch: expected %0d, got %0d",
                   $time, want.total, out_total_visits);
          fault_count++;
        end
        results_checked++;
      end
    end
    if (in_xfer || out_xfer || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_REGS; i++) weight[i] = DEFAULT_WT[i];
    for (i = 0; i < NUM_DAYS; i++) bucket[i] = '0;
    visits_total = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty query, wraparound clears, clear extremes, invalid day
    push_visit(3'd0, 8'd0, 8'd0);
    push_visit(3'd0, 8'd0, 8'd255);
    push_visit(3'd1, 8'd1, 8'd1);
    push_visit(3'd2, 8'd0, 8'd200);
    push_visit(3'd0, 8'd3, 8'd9);
    push_visit(3'd3, 8'd255, 8'd255);
    push_visit(DAY_INVALID, 8'd255, 8'd17);
    push_visit(DAY_INVALID, 8'd0, 8'd0);
    push_visit(3'd6, 8'd7, 8'd128);
    push_visit(3'd5, 8'd8, 8'd64);
    push_visit(3'd4, 8'd3, 8'd5);
    for (i = 1; i <= NUM_DAYS; i++) push_visit(3'(i % NUM_DAYS), 8'd0, 8'd255);
    push_visit(3'd3, 8'd0, 8'd0);
    push_visit(DAY_INVALID, 8'd0, 8'd255);
    push_visit(3'd2, 8'd2, 8'd0);
    push_visit(3'd6, 8'd1, 8'd255);
    drain();

    // Random phases under varied weights, one with no idling
    set_weights(WT_MAX);
    queue_random(140);
    drain();
    set_weights(WT_ZERO);
    queue_random(100);
    drain();
    set_weights(WT_RANDOM);
    idle_en = 1'b0;
    queue_random(150);
    drain();
    idle_en = 1'b1;
    set_weights(WT_MIXED);
    queue_random(150);
    drain();
    set_weights(WT_DEFAULT);
    queue_random(140);
    drain();

    repeat (8) @(negedge clk);
    $display("Ran %0d visit events through %0d weight settings (%0d register writes),",
             visits_queued, weight_sets + 1, cfg_writes);
    $display("checked %0d results with %0d faults.", results_checked, fault_count);
    if (fault_count == 0 && tally_due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
